>>> src/auto_white_balance_ycbcr_core_assert.svh
// assertion macros used by the white balance back part
`ifndef AUTO_WHITE_BALANCE_YCBCR_CORE_ASSERT_SVH
`define AUTO_WHITE_BALANCE_YCBCR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define AWB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("awb assertion failed");

// next-cycle implication, checked outside reset
`define AWB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("awb assertion failed");

`endif

>>> src/awb_pkg.sv
// ----------------------------------------------------------------------------
// awb_pkg
// Types and constants shared by the white balance core modules.
// ----------------------------------------------------------------------------
package awb_pkg;

  localparam int unsigned GAIN_W = 18;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 18'd65536;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 18'd262143;

  // gain steps in q16
  localparam logic [GAIN_W-1:0] STEP_COARSE = 18'd3277;
  localparam logic [GAIN_W-1:0] STEP_MID    = 18'd1311;
  localparam logic [GAIN_W-1:0] STEP_FINE   = 18'd328;
  localparam logic [GAIN_W-1:0] STEP_TINY   = 18'd66;

  localparam int unsigned THR_W = 10;
  localparam int unsigned ITER_W = 7;
  localparam logic signed [THR_W-1:0] THR_RESET = 10'sd180;
  localparam logic [ITER_W-1:0] ITER_RESET = 7'd80;

  // configuration register indexes
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_MAX_ITER  = 1'b1;

  // depth of the internal and result queues
  localparam int unsigned QDEPTH = 4;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } pix_t;

  typedef struct packed {
    pix_t              pix;
    logic              conv;
    logic [ITER_W-1:0] iter;
  } result_t;

  // gains from the back part, plus frame end completion
  typedef struct packed {
    logic [GAIN_W-1:0] blue;
    logic [GAIN_W-1:0] red;
    logic              done;
  } awb_gain_t;

endpackage

>>> src/awb_fifo.sv
// ----------------------------------------------------------------------------
// awb_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module awb_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  // storage write
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == LAST_PTR) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == LAST_PTR) ? '0 : rp_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> src/awb_front.sv
// ----------------------------------------------------------------------------
// awb_front
// Accepts pixels, applies blue and red gains, holds off after a frame end.
// ----------------------------------------------------------------------------
module awb_front import awb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  logic [7:0] blue_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] red_in_i,
  input  logic      frame_last_i,
  input  awb_gain_t gain_i,
  input  logic      q_full_i,
  output logic      q_push_o,
  output pix_t      q_data_o
);

  logic hold_q, hold_d;
  logic accept;

  // round half up and saturate to a byte
  function automatic logic [7:0] scale_ch(input logic [7:0] c, input logic [GAIN_W-1:0] g);
    logic [GAIN_W+8:0] prod;
    logic [GAIN_W-8:0] v;
    prod = {1'b0, c} * {9'd0, g} + (GAIN_W+9)'(32768);
    v    = prod[GAIN_W+8:16];
    return (v > (GAIN_W-7)'(255)) ? 8'd255 : v[7:0];
  endfunction

  assign full     = hold_q || q_full_i;
  assign accept   = push && !full;
  assign q_push_o = accept;

  // corrected pixel into the queue
  always_comb begin
    q_data_o.blue  = scale_ch(blue_in_i, gain_i.blue);
    q_data_o.green = green_in_i;
    q_data_o.red   = scale_ch(red_in_i, gain_i.red);
    q_data_o.last  = frame_last_i;
  end

  // hold after a frame end until the gains are settled for the next frame
  always_comb begin
    hold_d = hold_q;
    if (accept && frame_last_i) begin
      hold_d = 1'b1;
    end else if (gain_i.done) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

endmodule

>>> src/awb_back.sv
// ----------------------------------------------------------------------------
// awb_back
// Colour conversion, near-white sums and the frame end gain update.
// ----------------------------------------------------------------------------
`include "auto_white_balance_ycbcr_core_assert.svh"

module awb_back import awb_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 4194304
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [THR_W-1:0] thresh_i,
  input  logic [ITER_W-1:0]       max_iter_i,
  input  logic                    q_empty_i,
  input  pix_t                    q_data_i,
  output logic                    q_pop_o,
  input  logic                    of_full_i,
  output logic                    of_push_o,
  output result_t                 of_data_o,
  output awb_gain_t               gain_o
);

  localparam int unsigned NW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned TW = NW + 24;
  localparam int unsigned MW = TW + 4;
  localparam int unsigned SW = 2 * MW + 1;
  localparam logic [NW-1:0] PIX_LIMIT = NW'(MAX_PIXELS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQA  = 3'd1;
  localparam logic [2:0] ST_SQB  = 3'd2;
  localparam logic [2:0] ST_NSQ  = 3'd3;
  localparam logic [2:0] ST_DEC  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] st_q, st_d;

  logic               s1_v_q;
  pix_t               s1_pix_q;
  logic signed [26:0] s1_y_q, s1_cb_q, s1_cr_q;
  logic signed [26:0] y_c, cb_c, cr_c, white_m;

  logic signed [TW-1:0] cbt_q, crt_q, cbt_d, crt_d;
  logic [NW-1:0]        cnt_q, cnt_d;
  logic [TW-1:0]        cbm_q, crm_q, cbm_c, crm_c;
  logic                 cb_neg_q, cr_neg_q;

  logic [SW-1:0]     mc_q, acc_q;
  logic [MW-1:0]     mp_q;
  logic [2*NW-1:0]   nsq_q;
  logic [GAIN_W-1:0] bg_q, rg_q, step_c, g_sel, g_new;
  logic [GAIN_W:0]   g_up;
  logic              down_c, use_blue, chroma_big, do_upd;
  logic              settled_q;
  logic [ITER_W-1:0] iter_q;
  logic              idle, s1_adv, white;

  assign idle    = (st_q == ST_IDLE);
  assign s1_adv  = s1_v_q && idle && (s1_pix_q.last || !of_full_i);
  assign q_pop_o = !q_empty_i && idle && (!s1_v_q || (s1_adv && !s1_pix_q.last));

  // colour conversion in q16
  always_comb begin
    y_c  = 27'sd7471 * $signed({19'd0, q_data_i.blue})
         + 27'sd38470 * $signed({19'd0, q_data_i.green})
         + 27'sd19595 * $signed({19'd0, q_data_i.red});
    cb_c = 27'sd32768 * $signed({19'd0, q_data_i.blue})
         - 27'sd21710 * $signed({19'd0, q_data_i.green})
         - 27'sd11058 * $signed({19'd0, q_data_i.red});
    cr_c = 27'sd32768 * $signed({19'd0, q_data_i.red})
         - 27'sd27439 * $signed({19'd0, q_data_i.green})
         - 27'sd5329 * $signed({19'd0, q_data_i.blue});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (q_pop_o) begin
      s1_v_q <= 1'b1;
    end else if ((s1_adv && !s1_pix_q.last) || (st_q == ST_OUT && !of_full_i)) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_pix_q <= q_data_i;
      s1_y_q   <= y_c;
      s1_cb_q  <= cb_c;
      s1_cr_q  <= cr_c;
    end
  end

  // near-white test and frame sums
  always_comb begin
    white_m = s1_y_q - (s1_cb_q < 0 ? -s1_cb_q : s1_cb_q)
            - (s1_cr_q < 0 ? -s1_cr_q : s1_cr_q);
    white   = white_m > $signed({{1{thresh_i[THR_W-1]}}, thresh_i, 16'd0});
    cbt_d   = cbt_q;
    crt_d   = crt_q;
    cnt_d   = cnt_q;
    if (s1_adv && cnt_q < PIX_LIMIT) begin
      cnt_d = cnt_q + 1'b1;
      if (white) begin
        cbt_d = cbt_q + TW'(s1_cb_q);
        crt_d = crt_q + TW'(s1_cr_q);
      end
    end
    if (st_q == ST_DEC) begin
      cbt_d = '0;
      crt_d = '0;
      cnt_d = '0;
    end
    cbm_c = cbt_d[TW-1] ? TW'(-cbt_d) : TW'(cbt_d);
    crm_c = crt_d[TW-1] ? TW'(-crt_d) : TW'(crt_d);
  end

  // sequencer state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (s1_adv && s1_pix_q.last) st_d = ST_SQA;
      ST_SQA:  if (mp_q[MW-1:1] == '0) st_d = ST_SQB;
      ST_SQB:  if (mp_q[MW-1:1] == '0) st_d = ST_NSQ;
      ST_NSQ:  st_d = ST_DEC;
      ST_DEC:  st_d = ST_OUT;
      ST_OUT:  if (!of_full_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // gain update decision
  always_comb begin
    chroma_big = acc_q > SW'({nsq_q, 32'd0});
    do_upd     = !settled_q && (iter_q < max_iter_i) && chroma_big;
    use_blue   = cbm_q > crm_q;
    priority if (iter_q > 7'd55) step_c = STEP_TINY;
    else if (iter_q > 7'd40)     step_c = STEP_FINE;
    else if (iter_q > 7'd25)     step_c = STEP_MID;
    else                         step_c = STEP_COARSE;
    g_sel  = use_blue ? bg_q : rg_q;
    down_c = use_blue ? !cb_neg_q : (!cr_neg_q && crm_q != '0);
    g_up   = {1'b0, g_sel} + {1'b0, step_c};
    if (down_c) begin
      g_new = (g_sel > step_c) ? g_sel - step_c : '0;
    end else begin
      g_new = (g_up >= {1'b0, GAIN_MAX}) ? GAIN_MAX : g_up[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      cbt_q     <= '0;
      crt_q     <= '0;
      cnt_q     <= '0;
      bg_q      <= GAIN_ONE;
      rg_q      <= GAIN_ONE;
      settled_q <= 1'b0;
      iter_q    <= '0;
    end else begin
      st_q  <= st_d;
      cbt_q <= cbt_d;
      crt_q <= crt_d;
      cnt_q <= cnt_d;
      if (st_q == ST_DEC) begin
        if (do_upd) begin
          if (use_blue) begin
            bg_q <= g_new;
          end else begin
            rg_q <= g_new;
          end
          iter_q <= iter_q + 1'b1;
        end else begin
          settled_q <= 1'b1;
        end
      end
    end
  end

  // shift-add squaring of ten times each chroma magnitude
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        cbm_q    <= cbm_c;
        crm_q    <= crm_c;
        cb_neg_q <= cbt_d[TW-1];
        cr_neg_q <= crt_d[TW-1];
        mp_q     <= ({4'd0, cbm_c} << 3) + ({4'd0, cbm_c} << 1);
        mc_q     <= SW'(({4'd0, cbm_c} << 3) + ({4'd0, cbm_c} << 1));
        acc_q    <= '0;
      end
      ST_SQA, ST_SQB: begin
        if (mp_q[0]) begin
          acc_q <= acc_q + mc_q;
        end
        if (st_q == ST_SQA && mp_q[MW-1:1] == '0) begin
          mp_q <= ({4'd0, crm_q} << 3) + ({4'd0, crm_q} << 1);
          mc_q <= SW'(({4'd0, crm_q} << 3) + ({4'd0, crm_q} << 1));
        end else begin
          mp_q <= mp_q >> 1;
          mc_q <= mc_q << 1;
        end
      end
      ST_NSQ: nsq_q <= cnt_q * cnt_q;
      default: ;
    endcase
  end

  // results towards the output queue
  always_comb begin
    of_push_o      = (s1_adv && !s1_pix_q.last) || (st_q == ST_OUT && !of_full_i);
    of_data_o.pix  = s1_pix_q;
    of_data_o.conv = settled_q;
    of_data_o.iter = iter_q;
    gain_o.blue    = bg_q;
    gain_o.red     = rg_q;
    gain_o.done    = (st_q == ST_OUT) && !of_full_i;
  end

  `AWB_ASSERT_NXT(a_settled_sticky, settled_q, settled_q)
  `AWB_ASSERT_IMP(a_no_pop_busy, !idle, !q_pop_o)
  `AWB_ASSERT_NXT(a_iter_step, st_q != ST_DEC, iter_q == $past(iter_q))
  `AWB_ASSERT_IMP(a_frame_end_held, st_q == ST_OUT, s1_v_q && s1_pix_q.last)

endmodule

>>> src/auto_white_balance_ycbcr_core.sv
// path: a pixel is registered in the middle queue, the stage-one register and the result queue before the result ports
// throughput: one pixel per cycle inside a frame while the queues have room
// frame end: the serial squaring unit runs through the SQA and SQB states, then NSQ, DEC and OUT
// reset: gains to unity, sums and counters cleared, registers to reset values
// ----------------------------------------------------------------------------
// auto_white_balance_ycbcr_core
// Near-white auto white balance with per-frame gain adjustment.
// ----------------------------------------------------------------------------
module auto_white_balance_ycbcr_core import awb_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 4194304
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [THR_W-1:0]  cfg_data_i,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        blue_in_i,
  input  logic [7:0]        green_in_i,
  input  logic [7:0]        red_in_i,
  input  logic              frame_last_i,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        blue_out_o,
  output logic [7:0]        green_out_o,
  output logic [7:0]        red_out_o,
  output logic              frame_last_out_o,
  output logic              converged_o,
  output logic [ITER_W-1:0] iteration_count_o
);

  logic signed [THR_W-1:0] thresh_q;
  logic [ITER_W-1:0]       max_iter_q;
  awb_gain_t               gain;
  logic                    q_push, q_full, q_pop, q_empty;
  pix_t                    q_wdata, q_rdata;
  logic                    of_push, of_full;
  result_t                 of_wdata, of_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q   <= THR_RESET;
      max_iter_q <= ITER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESHOLD: thresh_q   <= $signed(cfg_data_i);
        REG_MAX_ITER:  max_iter_q <= cfg_data_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  awb_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .blue_in_i, .green_in_i, .red_in_i, .frame_last_i,
    .gain_i   (gain),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  // queue between the front and back parts
  awb_fifo #(.W($bits(pix_t)), .DEPTH(QDEPTH)) u_mid_q (
    .clk_i, .rst_ni,
    .push_i (q_push), .data_i (q_wdata), .full_o (q_full),
    .pop_i  (q_pop),  .data_o (q_rdata), .empty_o (q_empty)
  );

  awb_back #(.MAX_PIXELS(MAX_PIXELS)) u_back (
    .clk_i, .rst_ni,
    .thresh_i   (thresh_q),
    .max_iter_i (max_iter_q),
    .q_empty_i  (q_empty),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .of_full_i  (of_full),
    .of_push_o  (of_push),
    .of_data_o  (of_wdata),
    .gain_o     (gain)
  );

  // result queue
  awb_fifo #(.W($bits(result_t)), .DEPTH(QDEPTH)) u_res_q (
    .clk_i, .rst_ni,
    .push_i (of_push), .data_i (of_wdata), .full_o (of_full),
    .pop_i  (pop),     .data_o (of_rdata), .empty_o (empty)
  );

  assign blue_out_o        = of_rdata.pix.blue;
  assign green_out_o       = of_rdata.pix.green;
  assign red_out_o         = of_rdata.pix.red;
  assign frame_last_out_o  = of_rdata.pix.last;
  assign converged_o       = of_rdata.conv;
  assign iteration_count_o = of_rdata.iter;

endmodule

>>> test/awb_ycbcr_checker.sv
// ----------------------------------------------------------------------------
// awb_ycbcr_checker
// Watches the pixel, result and register channels of the white balance core,
// predicts every corrected pixel and the gain loop, and compares in order.
// ----------------------------------------------------------------------------
module awb_ycbcr_checker import awb_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 4194304
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [THR_W-1:0]  cfg_data_i,
  input  logic              push,
  input  logic              full,
  input  logic [7:0]        blue_in_i,
  input  logic [7:0]        green_in_i,
  input  logic [7:0]        red_in_i,
  input  logic              frame_last_i,
  input  logic              empty,
  input  logic              pop,
  input  logic [7:0]        blue_out_o,
  input  logic [7:0]        green_out_o,
  input  logic [7:0]        red_out_o,
  input  logic              frame_last_out_o,
  input  logic              converged_o,
  input  logic [ITER_W-1:0] iteration_count_o,
  output int                errors_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted state of the gain loop
  longint            thr_q;
  logic [ITER_W-1:0] max_iter_q;
  logic [GAIN_W-1:0] gain_b_q;
  logic [GAIN_W-1:0] gain_r_q;
  longint            cb_sum_q;
  longint            cr_sum_q;
  longint unsigned   pix_cnt_q;
  logic [ITER_W-1:0] updates_q;
  logic              settled_q;

  result_t pixels_due[$];
  int      errors;

  assign errors_o  = errors;
  assign pending_o = pixels_due.size();

  function automatic logic [7:0] scale_byte(logic [7:0] c, logic [GAIN_W-1:0] g);
    longint unsigned v;
    v = (longint'(c) * longint'(g) + 32768) >> 16;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [GAIN_W-1:0] step_gain(logic [GAIN_W-1:0] g,
                                                  logic [GAIN_W-1:0] st, logic down);
    if (down) return (g > st) ? g - st : '0;
    return ((GAIN_MAX - g) > st) ? g + st : GAIN_MAX;
  endfunction

  // frame end: gain move or settle
  function automatic void close_frame();
    logic [127:0]      mb, mr, mn;
    logic              chroma_big;
    logic [GAIN_W-1:0] st;
    mb = 128'(abs_l(cb_sum_q)) * 10;
    mr = 128'(abs_l(cr_sum_q)) * 10;
    mn = 128'(pix_cnt_q) << 16;
    chroma_big = (mb * mb + mr * mr) > (mn * mn);
    if (!settled_q && updates_q < max_iter_q && chroma_big) begin
      st = STEP_COARSE;
      if (updates_q > 25) st = STEP_MID;
      if (updates_q > 40) st = STEP_FINE;
      if (updates_q > 55) st = STEP_TINY;
      if (abs_l(cb_sum_q) > abs_l(cr_sum_q))
        gain_b_q = step_gain(gain_b_q, st, cb_sum_q > 0);
      else
        gain_r_q = step_gain(gain_r_q, st, cr_sum_q > 0);
      updates_q = updates_q + 1'b1;
    end else begin
      settled_q = 1'b1;
    end
    cb_sum_q  = 0;
    cr_sum_q  = 0;
    pix_cnt_q = 0;
  endfunction

  // one pixel through the correction and the statistics
  function automatic result_t correct_pixel(logic [7:0] b, logic [7:0] g,
                                            logic [7:0] r, logic last);
    result_t res;
    longint  bb, gg, rr, y, cb, cr;
    res.pix.blue  = scale_byte(b, gain_b_q);
    res.pix.green = g;
    res.pix.red   = scale_byte(r, gain_r_q);
    res.pix.last  = last;
    bb = res.pix.blue;
    gg = g;
    rr = res.pix.red;
    y  = 7471 * bb + 38470 * gg + 19595 * rr;
    cb = 32768 * bb - 21710 * gg - 11058 * rr;
    cr = 32768 * rr - 27439 * gg - 5329 * bb;
    if (pix_cnt_q < MAX_PIXELS) begin
      pix_cnt_q++;
      if (y - abs_l(cb) - abs_l(cr) > thr_q * 65536) begin
        cb_sum_q += cb;
        cr_sum_q += cr;
      end
    end
    if (last) close_frame();
    res.conv = settled_q;
    res.iter = updates_q;
    return res;
  endfunction

  // track registers, predict on input transfers, compare on result transfers
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want, got, fresh;
    if (!rst_ni) begin
      thr_q      = longint'(THR_RESET);
      max_iter_q = ITER_RESET;
      gain_b_q   = GAIN_ONE;
      gain_r_q   = GAIN_ONE;
      cb_sum_q   = 0;
      cr_sum_q   = 0;
      pix_cnt_q  = 0;
      updates_q  = '0;
      settled_q  = 1'b0;
      pixels_due.delete();
      errors     = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_THRESHOLD) thr_q = longint'($signed(cfg_data_i));
        else if (cfg_idx_i == REG_MAX_ITER) max_iter_q = cfg_data_i[ITER_W-1:0];
      end
      if (push && !full) begin
        fresh = correct_pixel(blue_in_i, green_in_i, red_in_i, frame_last_i);
        pixels_due.insert(pixels_due.size(), fresh);
      end
      if (pop && !empty) begin
        got.pix.blue  = blue_out_o;
        got.pix.green = green_out_o;
        got.pix.red   = red_out_o;
        got.pix.last  = frame_last_out_o;
        got.conv      = converged_o;
        got.iter      = iteration_count_o;
        if (pixels_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transfer: %p", got);
        end else begin
          want = pixels_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: expected b=%0d g=%0d r=%0d last=%0b conv=%0b iter=%0d,",
                        " got b=%0d g=%0d r=%0d last=%0b conv=%0b iter=%0d"},
                       want.pix.blue, want.pix.green, want.pix.red, want.pix.last,
                       want.conv, want.iter, got.pix.blue, got.pix.green,
                       got.pix.red, got.pix.last, got.conv, got.iter);
          end
        end
      end
    end
  end

endmodule

>>> test/tb_auto_white_balance_ycbcr_core.sv
// ----------------------------------------------------------------------------
// tb_auto_white_balance_ycbcr_core
// Drives pixel frames with random gaps and result stalls through several
// register settings; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_auto_white_balance_ycbcr_core import awb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PIXELS = 4194304;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned STALL_LIMIT = 3000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [THR_W-1:0]  cfg_data_i;
  logic              push;
  logic              full;
  logic [7:0]        blue_in_i;
  logic [7:0]        green_in_i;
  logic [7:0]        red_in_i;
  logic              frame_last_i;
  logic              empty;
  logic              pop;
  logic [7:0]        blue_out_o;
  logic [7:0]        green_out_o;
  logic [7:0]        red_out_o;
  logic              frame_last_out_o;
  logic              converged_o;
  logic [ITER_W-1:0] iteration_count_o;
  int                errors;
  int                pending;
  logic              in_done;
  logic              calm;
  int                quiet_cycles;

  auto_white_balance_ycbcr_core #(.MAX_PIXELS(MAX_PIXELS)) u_dut (.*);

  awb_ycbcr_checker #(.MAX_PIXELS(MAX_PIXELS)) u_checker (
    .*,
    .errors_o (errors),
    .pending_o(pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // input transfer flag and watchdog, both from pre-edge values
  always @(posedge clk_i) begin
    in_done <= push && !full;
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // mostly short gaps, a few long ones, none in calm stretches
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (calm || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side stalls
  initial begin
    int stall;
    pop = 1'b0;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push         <= 1'b1;
    blue_in_i    <= b;
    green_in_i   <= g;
    red_in_i     <= r;
    frame_last_i <= last;
    do @(negedge clk_i); while (!in_done);
  endtask

  // wait for all results plus the frame end work, then write a register
  task automatic write_reg(logic idx, logic [THR_W-1:0] value);
    push <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one frame of pixels with a colour cast picked per frame
  task automatic send_frame(int len);
    int         cast, v;
    logic [7:0] b, g, r;
    cast = $urandom_range(5);
    for (int i = 0; i < len; i++) begin
      v = $urandom_range(140, 235);
      case (cast)
        0: begin
          b = 8'($urandom); g = 8'($urandom); r = 8'($urandom);
        end
        1: begin
          b = 8'($urandom_range(200, 255)); g = 8'($urandom_range(150, 220));
          r = 8'($urandom_range(90, 180));
        end
        2: begin
          b = 8'($urandom_range(90, 180)); g = 8'($urandom_range(150, 220));
          r = 8'($urandom_range(200, 255));
        end
        3: begin
          b = 8'(v + $urandom_range(0, 20)); g = 8'(v);
          r = 8'(v + $urandom_range(0, 20));
        end
        4: begin
          b = {8{1'($urandom_range(1))}}; g = {8{1'($urandom_range(1))}};
          r = {8{1'($urandom_range(1))}};
        end
        default: begin
          b = 8'(v + $urandom_range(0, 20)); g = 8'(v - $urandom_range(0, 30));
          r = 8'(v - $urandom_range(0, 40));
        end
      endcase
      send_pixel(b, g, r, i == len - 1);
    end
  endtask

  task automatic random_frames(int items);
    int sent, len;
    sent = 0;
    while (sent < items) begin
      calm = ($urandom_range(9) == 0);
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      send_frame(len);
      sent += len;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_THRESHOLD;
    cfg_data_i   = '0;
    push         = 1'b0;
    blue_in_i    = '0;
    green_in_i   = '0;
    red_in_i     = '0;
    frame_last_i = 1'b0;
    calm         = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: near-white pixels with a slight cast
    send_pixel(8'd230, 8'd240, 8'd250, 1'b1);
    send_pixel(8'd250, 8'd240, 8'd215, 1'b0);
    send_pixel(8'd245, 8'd235, 8'd220, 1'b1);

    // lowest threshold: every pixel counts
    write_reg(REG_THRESHOLD, 10'h200);
    write_reg(REG_MAX_ITER, 10'd127);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd170, 8'd85, 8'd170, 1'b0);
    send_pixel(8'd85, 8'd170, 8'd85, 1'b1);
    // blue cast to drive the blue gain down towards its floor
    for (int i = 0; i < 24; i++) send_pixel(8'd255, 8'd0, 8'd40, 1'b1);
    // green-heavy pixels with no blue: the larger blue chroma sum steps the blue gain upwards
    for (int i = 0; i < 16; i++) send_pixel(8'd0, 8'd200, 8'd90, 1'b1);

    random_frames(360);

    write_reg(REG_THRESHOLD, 10'd0);
    random_frames(200);

    // limit below the update count: settles at the next frame end
    write_reg(REG_THRESHOLD, 10'($urandom_range(1023)));
    write_reg(REG_MAX_ITER, 10'd3);
    random_frames(150);

    // threshold of 255, no updates allowed
    write_reg(REG_THRESHOLD, 10'd255);
    write_reg(REG_MAX_ITER, 10'd0);
    random_frames(160);

    push <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
